/* hw/rtl/dsa_pkg.sv */
// shared types and constants for the descriptor slot allocator
`timescale 1ns / 1ps

package dsa_pkg;

  localparam int SLOT_W        = 11;    // slot numbers and the slot limit
  localparam int LOW_SLOTS_DEF = 32;
  localparam int EXT_SLOTS_DEF = 1024;
  localparam int MARK_W        = 32;    // extended marks packed per memory word
  localparam int MARK_LOG      = 5;     // log2 of MARK_W
  localparam int CFG_DATA_W    = 32;
  localparam int CFG_ADDR_W    = 2;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef enum logic {
    MODE_ALLOC = 1'b0,
    MODE_FREE  = 1'b1
  } mode_t;

endpackage

/* hw/rtl/descriptor_slot_allocator.sv */
// descriptor slot allocator: low bitmap in flops, extended marks in a word-packed memory
`timescale 1ns / 1ps

// Hands out and takes back slot numbers. A request is taken when start is high and busy
// is low; its result appears on the out_ ports for exactly one cycle with out_strobe, and
// the receiver cannot stall it. The result is registered from the accepting cycle for an
// allocate served from the low bitmap, for a full answer while no extended slots are
// enabled, for an out-of-range answer and for a free of a low slot. A free of an extended
// slot and an allocate that hits the hinted slot first read the slot's mark memory word
// (S_FREE, S_HINT) and register the result from that state. A scan, which also gives a
// full answer when extended slots are enabled, checks the 32-slot memory words in S_SCAN
// in order from word 0, after S_HINT when the hint missed first. The scan rate is set by
// the single read port of the mark memory, one word per cycle. After reset, and after every
// write of slot_limit that takes effect, the block sweeps the mark memory to zero, one word
// per cycle, and holds busy high meanwhile.
// One request is in flight at a time.
module descriptor_slot_allocator
  import dsa_pkg::*;
#(
  parameter int LOW_SLOTS = LOW_SLOTS_DEF,
  parameter int EXT_SLOTS = EXT_SLOTS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // request channel
  input  logic                   start,
  output logic                   busy,
  input  logic                   in_mode,
  input  logic [SLOT_W-1:0]      in_slot,
  // result channel
  output logic                   out_strobe,
  output logic [1:0]             out_status,
  output logic [SLOT_W-1:0]      out_granted_slot,
  // configuration
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [CFG_ADDR_W-1:0]  paddr,
  input  logic [CFG_DATA_W-1:0]  pwdata,
  output logic [CFG_DATA_W-1:0]  prdata,
  output logic                   pready
);

  localparam int NUM_WORDS = (EXT_SLOTS + MARK_W - 1) / MARK_W;
  localparam int WA_W      = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int IDX_W     = WA_W + MARK_LOG;
  localparam int CMP_W     = ((IDX_W > SLOT_W) ? IDX_W : SLOT_W) + 1;
  localparam int LP_W      = $clog2(LOW_SLOTS);
  localparam int MAX_LIMIT = LOW_SLOTS + EXT_SLOTS;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HINT,
    S_SCAN,
    S_FREE
  } state_t;

  state_t                state_r, state_nxt;
  logic [SLOT_W-1:0]     limit_r, limit_nxt;
  logic [LOW_SLOTS-1:0]  low_r, low_nxt;
  logic [SLOT_W-1:0]     hint_r, hint_nxt;
  logic [WA_W-1:0]       clr_cnt_r, clr_cnt_nxt;
  logic [WA_W-1:0]       scan_w_r, scan_w_nxt;
  logic [SLOT_W-1:0]     free_idx_r, free_idx_nxt;
  logic                  out_strobe_r, out_strobe_nxt;
  status_t               out_status_r, out_status_nxt;
  logic [SLOT_W-1:0]     out_slot_r, out_slot_nxt;

  // mark memory
  logic [MARK_W-1:0]     mark_mem [NUM_WORDS];
  logic [MARK_W-1:0]     rd_data_r;
  logic [WA_W-1:0]       rd_addr;
  logic                  wr_en;
  logic [WA_W-1:0]       wr_addr;
  logic [MARK_W-1:0]     wr_data;

  logic                  cfg_wr;
  logic [SLOT_W-1:0]     cfg_val;
  logic [SLOT_W-1:0]     ext_n;
  logic                  low_hit;
  logic [LP_W-1:0]       low_pos;
  logic [SLOT_W-1:0]     req_idx;
  logic [CMP_W-1:0]      scan_base;
  logic [CMP_W-1:0]      scan_rem;
  logic [MARK_W-1:0]     scan_free;
  logic                  word_hit;
  logic [MARK_LOG-1:0]   word_pos;
  logic [IDX_W-1:0]      scan_idx;
  logic [MARK_LOG-1:0]   hint_bit;
  logic [MARK_LOG-1:0]   free_bit;

  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_val = pwdata[SLOT_W-1:0];
  assign pready  = 1'b1;
  assign prdata  = CFG_DATA_W'(limit_r);

  assign busy             = (state_r != S_IDLE);
  assign out_strobe       = out_strobe_r;
  assign out_status       = out_status_r;
  assign out_granted_slot = out_slot_r;

  assign ext_n     = limit_r - SLOT_W'(LOW_SLOTS);
  assign req_idx   = in_slot - SLOT_W'(LOW_SLOTS);
  assign hint_bit  = hint_r[MARK_LOG-1:0];
  assign free_bit  = free_idx_r[MARK_LOG-1:0];
  assign scan_base = CMP_W'({scan_w_r, {MARK_LOG{1'b0}}});
  assign scan_rem  = CMP_W'(ext_n) - scan_base;
  assign scan_idx  = {scan_w_r, word_pos};

  // lowest clear bit of the low bitmap
  always_comb begin
    low_hit = 1'b0;
    low_pos = '0;
    for (int b = LOW_SLOTS - 1; b >= 0; b--) begin
      if (!low_r[b]) begin
        low_hit = 1'b1;
        low_pos = LP_W'(b);
      end
    end
  end

  // lowest clear mark of the current word that lies below the limit
  always_comb begin
    scan_free = '0;
    word_hit  = 1'b0;
    word_pos  = '0;
    for (int b = 0; b < MARK_W; b++) begin
      scan_free[b] = !rd_data_r[b] && (CMP_W'(b) < scan_rem);
    end
    for (int b = MARK_W - 1; b >= 0; b--) begin
      if (scan_free[b]) begin
        word_hit = 1'b1;
        word_pos = MARK_LOG'(b);
      end
    end
  end

  always_comb begin
    state_nxt      = state_r;
    limit_nxt      = limit_r;
    low_nxt        = low_r;
    hint_nxt       = hint_r;
    clr_cnt_nxt    = clr_cnt_r;
    scan_w_nxt     = scan_w_r;
    free_idx_nxt   = free_idx_r;
    out_strobe_nxt = 1'b0;
    out_status_nxt = out_status_r;
    out_slot_nxt   = out_slot_r;
    rd_addr        = '0;
    wr_en          = 1'b0;
    wr_addr        = '0;
    wr_data        = '0;

    case (state_r)
      S_CLEAR: begin
        wr_en       = 1'b1;
        wr_addr     = clr_cnt_r;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == WA_W'(NUM_WORDS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          if (in_mode == MODE_ALLOC) begin
            if (low_hit) begin
              low_nxt          = low_r | (LOW_SLOTS'(1) << low_pos);
              out_strobe_nxt   = 1'b1;
              out_status_nxt   = ST_OK;
              out_slot_nxt     = SLOT_W'(low_pos);
            end else if (ext_n == '0) begin
              out_strobe_nxt   = 1'b1;
              out_status_nxt   = ST_FULL;
              out_slot_nxt     = '0;
            end else if (hint_r < ext_n) begin
              rd_addr   = WA_W'(hint_r >> MARK_LOG);
              state_nxt = S_HINT;
            end else begin
              rd_addr    = '0;
              scan_w_nxt = '0;
              state_nxt  = S_SCAN;
            end
          end else begin
            if (in_slot >= limit_r) begin
              out_strobe_nxt = 1'b1;
              out_status_nxt = ST_RANGE;
              out_slot_nxt   = '0;
            end else if (in_slot < SLOT_W'(LOW_SLOTS)) begin
              low_nxt        = low_r & ~(LOW_SLOTS'(1) << in_slot);
              out_strobe_nxt = 1'b1;
              out_status_nxt = ST_OK;
              out_slot_nxt   = in_slot;
            end else begin
              rd_addr      = WA_W'(req_idx >> MARK_LOG);
              free_idx_nxt = req_idx;
              state_nxt    = S_FREE;
            end
          end
        end
      end
      S_HINT: begin
        if (!rd_data_r[hint_bit]) begin
          wr_en          = 1'b1;
          wr_addr        = WA_W'(hint_r >> MARK_LOG);
          wr_data        = rd_data_r | (MARK_W'(1) << hint_bit);
          hint_nxt       = hint_r + 1'b1;
          out_strobe_nxt = 1'b1;
          out_status_nxt = ST_OK;
          out_slot_nxt   = SLOT_W'(32'(hint_r) + LOW_SLOTS);
          state_nxt      = S_IDLE;
        end else begin
          // hinted slot taken: scan from the start
          rd_addr    = '0;
          scan_w_nxt = '0;
          state_nxt  = S_SCAN;
        end
      end
      S_SCAN: begin
        // next word is read ahead while this one is checked
        rd_addr    = scan_w_r + 1'b1;
        scan_w_nxt = scan_w_r + 1'b1;
        if (word_hit) begin
          wr_en          = 1'b1;
          wr_addr        = scan_w_r;
          wr_data        = rd_data_r | (MARK_W'(1) << word_pos);
          hint_nxt       = SLOT_W'(32'(scan_idx) + 1);
          out_strobe_nxt = 1'b1;
          out_status_nxt = ST_OK;
          out_slot_nxt   = SLOT_W'(32'(scan_idx) + LOW_SLOTS);
          state_nxt      = S_IDLE;
        end else if (scan_rem <= CMP_W'(MARK_W)) begin
          out_strobe_nxt = 1'b1;
          out_status_nxt = ST_FULL;
          out_slot_nxt   = '0;
          state_nxt      = S_IDLE;
        end
      end
      S_FREE: begin
        wr_en          = 1'b1;
        wr_addr        = WA_W'(free_idx_r >> MARK_LOG);
        wr_data        = rd_data_r & ~(MARK_W'(1) << free_bit);
        hint_nxt       = free_idx_r;
        out_strobe_nxt = 1'b1;
        out_status_nxt = ST_OK;
        out_slot_nxt   = SLOT_W'(32'(free_idx_r) + LOW_SLOTS);
        state_nxt      = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // a limit write above LOW_SLOTS restarts the clearing sweep
    if (cfg_wr && (paddr >> 2) == '0 && cfg_val > SLOT_W'(LOW_SLOTS)) begin
      if (32'(cfg_val) > MAX_LIMIT) begin
        limit_nxt = SLOT_W'(MAX_LIMIT);
      end else begin
        limit_nxt = cfg_val;
      end
      clr_cnt_nxt = '0;
      state_nxt   = S_CLEAR;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      limit_r      <= SLOT_W'(LOW_SLOTS);
      low_r        <= '0;
      hint_r       <= '0;
      clr_cnt_r    <= '0;
      scan_w_r     <= '0;
      free_idx_r   <= '0;
      out_strobe_r <= 1'b0;
      out_status_r <= ST_OK;
      out_slot_r   <= '0;
    end else begin
      state_r      <= state_nxt;
      limit_r      <= limit_nxt;
      low_r        <= low_nxt;
      hint_r       <= hint_nxt;
      clr_cnt_r    <= clr_cnt_nxt;
      scan_w_r     <= scan_w_nxt;
      free_idx_r   <= free_idx_nxt;
      out_strobe_r <= out_strobe_nxt;
      out_status_r <= out_status_nxt;
      out_slot_r   <= out_slot_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mark_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mark_mem[wr_addr] <= wr_data;
    end
  end

endmodule

/* hw/rtl/dsa_checker.sv */
// port-level checks for the descriptor slot allocator, bound to the top level
`timescale 1ns / 1ps

module dsa_checker
  import dsa_pkg::*;
#(
  parameter int LOW_SLOTS = LOW_SLOTS_DEF
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  start,
  input logic                  busy,
  input logic                  in_mode,
  input logic                  out_strobe,
  input logic [1:0]            out_status,
  input logic [SLOT_W-1:0]     out_granted_slot,
  input logic                  psel,
  input logic                  penable,
  input logic                  pwrite,
  input logic [CFG_DATA_W-1:0] pwdata
);

  logic req_acc;
  logic limit_wr;

  assign req_acc  = start && !busy;
  assign limit_wr = psel && penable && pwrite && (pwdata[SLOT_W-1:0] > SLOT_W'(LOW_SLOTS));

  // a failed request never reports a slot
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_status != ST_OK) |-> out_granted_slot == '0)
    else $error("nonzero slot on a failed request");

  // an accepted request either answers at once or keeps the block busy
  a_req_progress: assert property (@(posedge clk) disable iff (!rst_n)
    req_acc |=> (busy || out_strobe))
    else $error("request dropped");

  // every result follows an accepted request or work in progress
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start || busy))
    else $error("result without a request");

  // out of range is only reported for a free, right after it is taken
  a_range_free: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_status == ST_RANGE) |-> $past(req_acc && in_mode == MODE_FREE))
    else $error("range status not from a free");

  // an enabling limit write starts the clearing sweep
  a_limit_clear: assert property (@(posedge clk) disable iff (!rst_n)
    limit_wr |=> busy)
    else $error("limit write did not start the sweep");

endmodule

bind descriptor_slot_allocator dsa_checker #(
  .LOW_SLOTS(LOW_SLOTS)
) u_dsa_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .in_mode          (in_mode),
  .out_strobe       (out_strobe),
  .out_status       (out_status),
  .out_granted_slot (out_granted_slot),
  .psel             (psel),
  .penable          (penable),
  .pwrite           (pwrite),
  .pwdata           (pwdata)
);
